// File: src/slbm_pkg.sv
// Shared types, register codes and constants for the serial-loaded bank mapper.
// Depends on nothing; every other file in src imports it.
package slbm_pkg;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [1:0] mirror_mode;
    logic [6:0] prg_low_bank;
    logic [6:0] prg_high_bank;
    logic       chr_update;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
  } out_item_t;

  // Result handed from the core to the output queue
  typedef struct packed {
    logic      push;
    out_item_t item;
  } commit_t;

  typedef logic [4:0] bank_reg_t;

  localparam logic [1:0] RegControl = 2'd0;
  localparam logic [1:0] RegChr0    = 2'd1;
  localparam logic [1:0] RegChr1    = 2'd2;
  localparam logic [1:0] RegPrg     = 2'd3;

  localparam logic [1:0] CfgPrgBanks   = 2'd0;
  localparam logic [1:0] CfgChrPresent = 2'd1;

  localparam logic [6:0] SizeClass512k  = 7'd32;
  localparam logic [6:0] SizeClass1024k = 7'd64;
  localparam bank_reg_t  ControlResetValue = 5'h0c;
  localparam logic [2:0] BitsPerLoad = 3'd5;

endpackage

// File: src/serial_loaded_bank_mapper_top.sv
// Top level of the serial-loaded bank mapper: configuration registers and channels.
// Depends on slbm_pkg, slbm_core and slbm_out_queue.

// The block takes one CPU write per transfer. A data byte with bit 7 set resets
// the mapping registers (control becomes 0x0c) and yields a result at once;
// any other byte shifts its bit 0 into a five-bit latch, least significant bit
// first, and the fifth such byte loads the latch into the register chosen by
// address bits 14..13 and yields a result. Each result reports the mirroring
// mode, both 16K program banks (with the 512K/1024K size-class offsets) and,
// when character ROM is present, both 4K character banks. An input transfer
// can be taken every cycle: the state updates on the transfer and the result
// appears on the output in the following cycle, held in a two-entry queue, so input
// only stalls when two results are waiting. Write prg_banks (index 0) and
// chr_present (index 1) only while the block is idle.
module serial_loaded_bank_mapper_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  slbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slbm_pkg::out_item_t out_data
);
  import slbm_pkg::*;

  logic [6:0] prg_banks;
  logic       chr_present;
  logic       in_fire;
  logic       queue_full;
  commit_t    commit;

  // Hold configuration; writes to unused indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks   <= 7'd2;
      chr_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgPrgBanks:   prg_banks   <= cfg_data;
        CfgChrPresent: chr_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stall only when the queue has no room left for a result
  assign in_stall = queue_full;
  assign in_fire  = in_valid && !in_stall;

  slbm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .item        (in_data),
    .prg_banks   (prg_banks),
    .chr_present (chr_present),
    .commit      (commit)
  );

  slbm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .commit    (commit),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/slbm_core.sv
// Serial shift latch, bank registers and bank mapping for the bank mapper.
// Depends on slbm_pkg for the item types and register codes.
module slbm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  slbm_pkg::in_item_t  item,
  input  logic [6:0]          prg_banks,
  input  logic                chr_present,
  output slbm_pkg::commit_t   commit
);
  import slbm_pkg::*;

  bank_reg_t  bank_regs [4];
  bank_reg_t  bank_regs_next [4];
  logic [4:0] shift_latch;
  logic [4:0] shift_latch_next;
  logic [2:0] bit_count;
  logic [2:0] bit_count_next;

  logic [1:0] sel;
  logic       reset_byte;
  logic       load_done;
  logic [2:0] count_inc;
  logic [4:0] latch_set;
  logic [6:0] base;
  logic [6:0] prg_sum;
  logic [6:0] lo;
  logic [6:0] hi;
  logic [4:0] clo;
  logic [4:0] chi;
  bank_reg_t  ctl;
  bank_reg_t  c1;
  bank_reg_t  c2;

  assign sel        = item.address[14:13];
  assign reset_byte = item.data[7];
  assign count_inc  = bit_count + 3'd1;
  assign load_done  = (count_inc >= BitsPerLoad);
  assign latch_set  = shift_latch | (5'(item.data[0]) << bit_count);

  always_comb begin
    bank_regs_next   = bank_regs;
    shift_latch_next = shift_latch;
    bit_count_next   = bit_count;
    if (reset_byte) begin
      bank_regs_next[RegControl] = ControlResetValue;
      bank_regs_next[RegChr0]    = '0;
      bank_regs_next[RegChr1]    = '0;
      bank_regs_next[RegPrg]     = '0;
      shift_latch_next           = '0;
      bit_count_next             = '0;
    end else if (load_done) begin
      bank_regs_next[sel] = latch_set;
      shift_latch_next    = '0;
      bit_count_next      = '0;
    end else begin
      shift_latch_next = latch_set;
      bit_count_next   = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) bank_regs[i] <= '0;
      shift_latch <= '0;
      bit_count   <= '0;
    end else if (fire) begin
      bank_regs   <= bank_regs_next;
      shift_latch <= shift_latch_next;
      bit_count   <= bit_count_next;
    end
  end

  // Map from the register values as they stand after this transfer
  assign ctl = bank_regs_next[RegControl];
  assign c1  = bank_regs_next[RegChr0];
  assign c2  = bank_regs_next[RegChr1];

  always_comb begin
    if (prg_banks == SizeClass512k) begin
      base = c1[4] ? 7'd16 : 7'd0;
    end else if (prg_banks == SizeClass1024k) begin
      if (ctl[4]) begin
        base = (c1[4] ? 7'd16 : 7'd0) + (c2[4] ? 7'd32 : 7'd0);
      end else begin
        base = c1[4] ? 7'd48 : 7'd0;
      end
    end else begin
      base = 7'd0;
    end
  end

  assign prg_sum = 7'(bank_regs_next[RegPrg]) + base;

  always_comb begin
    if (ctl[3]) begin
      if (ctl[2]) begin
        lo = prg_sum;
        hi = prg_banks - 7'd1;
      end else begin
        lo = '0;
        hi = prg_sum;
      end
    end else begin
      lo = 7'({bank_regs_next[RegPrg][4:1], 1'b0}) + base;
      hi = lo + 7'd1;
    end
  end

  always_comb begin
    clo = '0;
    chi = '0;
    if (chr_present) begin
      if (ctl[4]) begin
        clo = c1;
        chi = c2;
      end else begin
        clo = {c1[4:1], 1'b0};
        chi = clo + 5'd1;
      end
    end
  end

  assign commit.push               = fire && (reset_byte || load_done);
  assign commit.item.reg_index     = sel;
  assign commit.item.mirror_mode   = ctl[1:0];
  assign commit.item.prg_low_bank  = lo;
  assign commit.item.prg_high_bank = hi;
  assign commit.item.chr_update    = chr_present;
  assign commit.item.chr_low_bank  = clo;
  assign commit.item.chr_high_bank = chi;

endmodule

// File: src/slbm_out_queue.sv
// Two-entry result queue that parts the core from the output channel.
// Depends on slbm_pkg for the result types.
module slbm_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  slbm_pkg::commit_t   commit,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output slbm_pkg::out_item_t out_data
);
  import slbm_pkg::*;

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (commit.push) slots[wr_ptr] <= commit.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (commit.push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(commit.push) - 2'(pop);
    end
  end

endmodule
